@@ rtl/wrol_pkg.sv @@
// ----------------------------------------------------------------------------
// wrol_pkg: shared constants of the write ring offset lookup unit
// Field widths and command codes that the unit and its checker share.
// ----------------------------------------------------------------------------
package wrol_pkg;

    localparam int HANDLE_W = 32;
    localparam int OFFSET_W = 24;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

endpackage

@@ rtl/write_ring_offset_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// write_ring_offset_lookup_unit: ring of write records with offset lookup
// Sequence: an add reads the slot it overwrites, writes it and then presents
// the result; a find walks 1..RING_DEPTH records, one record per cycle
// through the shared accumulate/compare unit and the single RAM read port;
// a find on an empty ring answers in the cycle after accept.
// Throughput: one transaction at a time; next accept after the result is taken.
// Reset: synchronous active low; clears slot pointers, full flag and all valid bits.
// ----------------------------------------------------------------------------
module write_ring_offset_lookup_unit #(
    parameter int RING_DEPTH = 16,
    parameter int SIZE_BITS  = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [wrol_pkg::HANDLE_W-1:0] i_entry_handle,
    input  logic [SIZE_BITS-1:0]          i_entry_size,
    input  logic [wrol_pkg::OFFSET_W-1:0] i_char_offset,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [wrol_pkg::HANDLE_W-1:0] o_found_handle,
    output logic [SIZE_BITS-1:0]          o_found_size,
    output logic [SIZE_BITS-1:0]          o_byte_in_entry,
    output logic                          o_evicted,
    output logic [wrol_pkg::HANDLE_W-1:0] o_evicted_handle,
    output logic                          o_ring_full
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int ACC_W  = SIZE_BITS + IDX_W;
    localparam int DATA_W = wrol_pkg::HANDLE_W + SIZE_BITS;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADD_RD = 3'd1;
    localparam logic [2:0] ST_ADD_WR = 3'd2;
    localparam logic [2:0] ST_FIND_RD = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    // Control state
    logic [2:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_ws, n_ws;
    logic [IDX_W-1:0]      r_os, n_os;
    logic                  r_full, n_full;
    logic [RING_DEPTH-1:0] r_valid, n_valid;
    logic                  r_rd_vld;

    // Working registers of the current transaction
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [IDX_W-1:0]              r_cnt, n_cnt;
    logic [ACC_W-1:0]              r_acc, n_acc;
    logic [wrol_pkg::HANDLE_W-1:0] r_hnd, n_hnd;
    logic [SIZE_BITS-1:0]          r_sz, n_sz;
    logic [wrol_pkg::OFFSET_W-1:0] r_off, n_off;

    // Result registers
    logic                          r_found, n_found;
    logic [wrol_pkg::HANDLE_W-1:0] r_fhnd, n_fhnd;
    logic [SIZE_BITS-1:0]          r_fsz, n_fsz;
    logic [SIZE_BITS-1:0]          r_fbyte, n_fbyte;
    logic                          r_ev, n_ev;
    logic [wrol_pkg::HANDLE_W-1:0] r_evh, n_evh;

    // RAM and datapath wires
    logic                          w_we;
    logic [IDX_W-1:0]              w_raddr;
    logic [DATA_W-1:0]             w_rdata;
    logic [wrol_pkg::HANDLE_W-1:0] w_rec_hnd;
    logic [SIZE_BITS-1:0]          w_rec_sz;
    logic [IDX_W-1:0]              w_nidx;
    logic                          w_hit;
    logic [ACC_W-1:0]              w_sum;
    logic [SIZE_BITS-1:0]          w_byte;
    logic                          w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Advance the walk index with wrap at the ring depth
    assign w_nidx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    // While walking, fetch the next record ahead so one record is checked per cycle
    assign w_raddr = (r_state == ST_WALK) ? w_nidx : r_idx;
    assign w_we    = (r_state == ST_ADD_WR);

    // A slot never written reads as an empty record
    assign w_rec_hnd = r_rd_vld ? w_rdata[DATA_W-1 -: wrol_pkg::HANDLE_W] : '0;
    assign w_rec_sz  = r_rd_vld ? w_rdata[SIZE_BITS-1:0] : '0;

    wrol_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ws),
        .i_wdata ({r_hnd, r_sz}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    wrol_step #(
        .SIZE_BITS (SIZE_BITS),
        .ACC_W     (ACC_W)
    ) u_step (
        .i_acc      (r_acc),
        .i_size     (w_rec_sz),
        .i_offset   (r_off),
        .o_hit      (w_hit),
        .o_next_acc (w_sum),
        .o_byte     (w_byte)
    );

    always_comb begin
        n_state = r_state;
        n_ws    = r_ws;
        n_os    = r_os;
        n_full  = r_full;
        n_valid = r_valid;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_hnd   = r_hnd;
        n_sz    = r_sz;
        n_off   = r_off;
        n_found = r_found;
        n_fhnd  = r_fhnd;
        n_fsz   = r_fsz;
        n_fbyte = r_fbyte;
        n_ev    = r_ev;
        n_evh   = r_evh;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // Latch the transaction and clear the result fields
                    n_hnd   = i_entry_handle;
                    n_sz    = i_entry_size;
                    n_off   = i_char_offset;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_found = 1'b0;
                    n_fhnd  = '0;
                    n_fsz   = '0;
                    n_fbyte = '0;
                    n_ev    = 1'b0;
                    n_evh   = '0;
                    if (i_command == wrol_pkg::CMD_ADD) begin
                        n_idx   = r_ws;
                        n_state = ST_ADD_RD;
                    end else if (!r_full && (r_ws == r_os)) begin
                        // Empty ring: answer not-found at once
                        n_state = ST_OUT;
                    end else begin
                        n_idx   = r_os;
                        n_state = ST_FIND_RD;
                    end
                end
            end
            ST_ADD_RD: begin
                // Read the slot about to be overwritten
                n_state = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                n_valid[r_ws] = 1'b1;
                n_ev          = r_full;
                n_evh         = r_full ? w_rec_hnd : '0;
                n_ws          = (r_ws == LAST_IDX) ? '0 : r_ws + 1'b1;
                if (r_full) begin
                    // Drop the oldest record along with the overwrite
                    n_os = n_ws;
                end else if (n_ws == r_os) begin
                    n_full = 1'b1;
                end
                n_state = ST_OUT;
            end
            ST_FIND_RD: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if ((w_rec_hnd == '0) || (w_rec_sz == '0)) begin
                    n_state = ST_OUT;
                end else if (w_hit) begin
                    n_found = 1'b1;
                    n_fhnd  = w_rec_hnd;
                    n_fsz   = w_rec_sz;
                    n_fbyte = w_byte;
                    n_state = ST_OUT;
                end else begin
                    n_acc = w_sum;
                    if ((!r_full && (w_nidx == r_ws)) || (r_cnt == LAST_IDX)) begin
                        n_state = ST_OUT;
                    end else begin
                        n_idx = w_nidx;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                // Hold the result until the sink takes it
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ws    <= '0;
            r_os    <= '0;
            r_full  <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_ws    <= n_ws;
            r_os    <= n_os;
            r_full  <= n_full;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[w_raddr];
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_hnd    <= n_hnd;
        r_sz     <= n_sz;
        r_off    <= n_off;
        r_found  <= n_found;
        r_fhnd   <= n_fhnd;
        r_fsz    <= n_fsz;
        r_fbyte  <= n_fbyte;
        r_ev     <= n_ev;
        r_evh    <= n_evh;
    end

    assign o_out_valid      = (r_state == ST_OUT);
    assign o_found          = r_found;
    assign o_found_handle   = r_fhnd;
    assign o_found_size     = r_fsz;
    assign o_byte_in_entry  = r_fbyte;
    assign o_evicted        = r_ev;
    assign o_evicted_handle = r_evh;
    assign o_ring_full      = r_full;

endmodule

@@ rtl/wrol_ram.sv @@
// ----------------------------------------------------------------------------
// wrol_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wrol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/wrol_step.sv @@
// ----------------------------------------------------------------------------
// wrol_step: accumulate and compare unit of the offset walk
// Adds one record size to the running offset and checks whether the
// requested offset falls inside that record.
// ----------------------------------------------------------------------------
module wrol_step #(
    parameter int SIZE_BITS = 20,
    parameter int ACC_W     = 24
) (
    input  logic [ACC_W-1:0]              i_acc,
    input  logic [SIZE_BITS-1:0]          i_size,
    input  logic [wrol_pkg::OFFSET_W-1:0] i_offset,
    output logic                          o_hit,
    output logic [ACC_W-1:0]              o_next_acc,
    output logic [SIZE_BITS-1:0]          o_byte
);

    localparam int CMP_W = (ACC_W > wrol_pkg::OFFSET_W) ? ACC_W : wrol_pkg::OFFSET_W;

    logic [CMP_W-1:0] w_acc;
    logic [CMP_W-1:0] w_sum;
    logic [CMP_W-1:0] w_off;
    logic [CMP_W-1:0] w_diff;

    assign w_acc  = CMP_W'(i_acc);
    assign w_off  = CMP_W'(i_offset);
    assign w_sum  = w_acc + CMP_W'(i_size);
    assign w_diff = w_off - w_acc;

    assign o_hit      = (w_off < w_sum);
    assign o_next_acc = w_sum[ACC_W-1:0];
    assign o_byte     = w_diff[SIZE_BITS-1:0];

endmodule

@@ rtl/wrol_checker.sv @@
// ----------------------------------------------------------------------------
// wrol_checker: port-level assertions for the write ring offset lookup unit
// Watches both channels and the result fields over time.
// ----------------------------------------------------------------------------
module wrol_checker #(
    parameter int SIZE_BITS = 20
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_command,
    input logic [wrol_pkg::HANDLE_W-1:0] i_entry_handle,
    input logic [SIZE_BITS-1:0]          i_entry_size,
    input logic [wrol_pkg::OFFSET_W-1:0] i_char_offset,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_found,
    input logic [wrol_pkg::HANDLE_W-1:0] o_found_handle,
    input logic [SIZE_BITS-1:0]          o_found_size,
    input logic [SIZE_BITS-1:0]          o_byte_in_entry,
    input logic                          o_evicted,
    input logic [wrol_pkg::HANDLE_W-1:0] o_evicted_handle,
    input logic                          o_ring_full
);

    // One transaction at a time: never ready while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    // A stalled result holds its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_found) && $stable(o_found_handle)
             && $stable(o_byte_in_entry) && $stable(o_evicted_handle)))
        else $error("stalled result changed");

    // A hit lies inside its record and never reports an eviction
    a_hit_in_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |->
            ((o_byte_in_entry < o_found_size) && !o_evicted && (o_evicted_handle == '0)))
        else $error("found result out of record or with eviction");

    // A miss or an add carries zero lookup fields; an eviction implies a full ring
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
            ((o_found_handle == '0) && (o_found_size == '0) && (o_byte_in_entry == '0)
             && (!o_evicted || o_ring_full)))
        else $error("miss with nonzero lookup fields or eviction without full ring");

    // Leaving reset the unit is idle and empty
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (o_in_ready && !o_out_valid && !o_ring_full))
        else $error("unit not idle after reset");

endmodule

bind write_ring_offset_lookup_unit wrol_checker #(.SIZE_BITS(SIZE_BITS)) u_wrol_checker (.*);

@@ bench/ring_lookup_checker.sv @@
// ----------------------------------------------------------------------------
// ring_lookup_checker: scoreboard for the write ring offset lookup unit
// Watches both channels, keeps its own copy of the record ring, predicts
// the reply of every accepted transaction and compares the replies in order.
// ----------------------------------------------------------------------------
module ring_lookup_checker #(
    parameter int RING_DEPTH = 16,
    parameter int SIZE_BITS  = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_command,
    input  logic [wrol_pkg::HANDLE_W-1:0] i_entry_handle,
    input  logic [SIZE_BITS-1:0]          i_entry_size,
    input  logic [wrol_pkg::OFFSET_W-1:0] i_char_offset,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_found,
    input  logic [wrol_pkg::HANDLE_W-1:0] i_found_handle,
    input  logic [SIZE_BITS-1:0]          i_found_size,
    input  logic [SIZE_BITS-1:0]          i_byte_in_entry,
    input  logic                          i_evicted,
    input  logic [wrol_pkg::HANDLE_W-1:0] i_evicted_handle,
    input  logic                          i_ring_full,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_hits,
    output int                            o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HANDLE_W = wrol_pkg::HANDLE_W;
    localparam int OFFSET_W = wrol_pkg::OFFSET_W;

    typedef struct packed {
        logic                 found;
        logic [HANDLE_W-1:0]  found_handle;
        logic [SIZE_BITS-1:0] found_size;
        logic [SIZE_BITS-1:0] byte_in_entry;
        logic                 evicted;
        logic [HANDLE_W-1:0]  evicted_handle;
        logic                 ring_full;
    } t_ring_reply;

    logic [HANDLE_W-1:0]  rec_handle [RING_DEPTH];
    logic [SIZE_BITS-1:0] rec_size   [RING_DEPTH];
    int                   wr_slot;
    int                   old_slot;
    logic                 model_full;

    t_ring_reply ring_reply_q[$];
    int          fail_total;
    int          hit_total;
    int          evict_total;

    // Apply one command to the shadow ring and return the reply it must produce.
    function automatic t_ring_reply model_ring_command(
        logic                 cmd,
        logic [HANDLE_W-1:0]  hnd,
        logic [SIZE_BITS-1:0] sz,
        logic [OFFSET_W-1:0]  off
    );
        t_ring_reply r;
        logic [63:0] run_sum;
        int          slot;
        int          walked;
        logic        done;
        r = '0;
        if (cmd == wrol_pkg::CMD_ADD) begin
            if (model_full) begin
                r.evicted        = 1'b1;
                r.evicted_handle = rec_handle[wr_slot];
            end
            rec_handle[wr_slot] = hnd;
            rec_size[wr_slot]   = sz;
            wr_slot = (wr_slot + 1) % RING_DEPTH;
            // on overwrite the oldest record moves along with the write slot
            if (model_full)
                old_slot = wr_slot;
            else if (wr_slot == old_slot)
                model_full = 1'b1;
        end else if (model_full || wr_slot != old_slot) begin
            run_sum = '0;
            slot    = old_slot;
            done    = 1'b0;
            for (walked = 0; walked < RING_DEPTH && !done; walked++) begin
                if (rec_handle[slot] == '0 || rec_size[slot] == '0) begin
                    done = 1'b1;
                end else if (64'(off) < run_sum + 64'(rec_size[slot])) begin
                    r.found         = 1'b1;
                    r.found_handle  = rec_handle[slot];
                    r.found_size    = rec_size[slot];
                    r.byte_in_entry = SIZE_BITS'(64'(off) - run_sum);
                    done = 1'b1;
                end else begin
                    run_sum += 64'(rec_size[slot]);
                    slot = (slot + 1) % RING_DEPTH;
                    if (!model_full && slot == wr_slot)
                        done = 1'b1;
                end
            end
        end
        r.ring_full = model_full;
        return r;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            fail_total++;
        end
    endfunction

    initial begin
        fail_total  = 0;
        hit_total   = 0;
        evict_total = 0;
    end

    always @(posedge i_clk) begin
        t_ring_reply want;
        if (!i_rst_n) begin
            for (int k = 0; k < RING_DEPTH; k++) begin
                rec_handle[k] = '0;
                rec_size[k]   = '0;
            end
            wr_slot    = 0;
            old_slot   = 0;
            model_full = 1'b0;
            ring_reply_q.delete();
        end else begin
            // a reply leaving at this edge never belongs to a command accepted here
            if (i_out_valid && i_out_ready) begin
                if (ring_reply_q.size() == 0) begin
                    $error("reply with no transaction outstanding");
                    fail_total++;
                end else begin
                    want = ring_reply_q.pop_front();
                    check_field("found",          64'(want.found),          64'(i_found));
                    check_field("found_handle",   64'(want.found_handle),   64'(i_found_handle));
                    check_field("found_size",     64'(want.found_size),     64'(i_found_size));
                    check_field("byte_in_entry",  64'(want.byte_in_entry),  64'(i_byte_in_entry));
                    check_field("evicted",        64'(want.evicted),        64'(i_evicted));
                    check_field("evicted_handle", 64'(want.evicted_handle), 64'(i_evicted_handle));
                    check_field("ring_full",      64'(want.ring_full),      64'(i_ring_full));
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = model_ring_command(i_command, i_entry_handle, i_entry_size,
                                          i_char_offset);
                if (want.found)
                    hit_total++;
                if (want.evicted)
                    evict_total++;
                ring_reply_q.push_back(want);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= ring_reply_q.size();
        o_hits       <= hit_total;
        o_evictions  <= evict_total;
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top of the write ring offset lookup unit testbench
// Drives add and find commands with random idles and back-pressure, holds
// the receiver off once and drains the unit at phase boundaries; the checker
// beside the unit predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HANDLE_W       = wrol_pkg::HANDLE_W;
    localparam int OFFSET_W       = wrol_pkg::OFFSET_W;
    localparam int RING_DEPTH     = 16;
    localparam int SIZE_BITS      = 20;
    localparam int RANDOM_ITEMS   = 1225;
    localparam int RECEIVER_HOLD  = 400;   // long hold-off on the reply side
    localparam int SETTLE_CYCLES  = 24;    // margin after the final drain
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transaction

    localparam logic [SIZE_BITS-1:0] SIZE_MAX   = '1;
    localparam logic [OFFSET_W-1:0]  OFFSET_MAX = '1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_command;
    logic [HANDLE_W-1:0]  i_entry_handle;
    logic [SIZE_BITS-1:0] i_entry_size;
    logic [OFFSET_W-1:0]  i_char_offset;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_found;
    logic [HANDLE_W-1:0]  o_found_handle;
    logic [SIZE_BITS-1:0] o_found_size;
    logic [SIZE_BITS-1:0] o_byte_in_entry;
    logic                 o_evicted;
    logic [HANDLE_W-1:0]  o_evicted_handle;
    logic                 o_ring_full;

    int fail_count;
    int pending;
    int hit_count;
    int evict_count;

    // phase flags shared with the reply side; written with NBAs only
    logic calm_phase    = 1'b0;
    logic hold_request  = 1'b0;

    int   add_count  = 0;
    int   find_count = 0;
    logic [SIZE_BITS-1:0] recent_sizes[$];   // sizes of the newest records, oldest first

    always #10 i_clk = ~i_clk;

    write_ring_offset_lookup_unit #(
        .RING_DEPTH (RING_DEPTH),
        .SIZE_BITS  (SIZE_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_entry_handle   (i_entry_handle),
        .i_entry_size     (i_entry_size),
        .i_char_offset    (i_char_offset),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_found_handle   (o_found_handle),
        .o_found_size     (o_found_size),
        .o_byte_in_entry  (o_byte_in_entry),
        .o_evicted        (o_evicted),
        .o_evicted_handle (o_evicted_handle),
        .o_ring_full      (o_ring_full)
    );

    ring_lookup_checker #(
        .RING_DEPTH (RING_DEPTH),
        .SIZE_BITS  (SIZE_BITS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_entry_handle   (i_entry_handle),
        .i_entry_size     (i_entry_size),
        .i_char_offset    (i_char_offset),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_found          (o_found),
        .i_found_handle   (o_found_handle),
        .i_found_size     (o_found_size),
        .i_byte_in_entry  (o_byte_in_entry),
        .i_evicted        (o_evicted),
        .i_evicted_handle (o_evicted_handle),
        .i_ring_full      (o_ring_full),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_hits           (hit_count),
        .o_evictions      (evict_count)
    );

    // Reply side: random back-pressure, one long hold-off on request, and no
    // stalls at all while the calm phase is on. The hold is counted here.
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left   <= RECEIVER_HOLD;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm_phase || ($urandom_range(0, 99) >= 34);
        end
    end

    // Watchdog: end the run when no transaction moves on either channel for
    // too long. Normal stalls, the long hold-off included, stay far below it.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Offer one command and return at the edge where it is accepted. Idle
    // cycles come before the command, one coin per cycle, so valid is never
    // dropped and raised again within one edge.
    task automatic offer(
        input logic                 cmd,
        input logic [HANDLE_W-1:0]  hnd,
        input logic [SIZE_BITS-1:0] sz,
        input logic [OFFSET_W-1:0]  off,
        input bit                   may_idle
    );
        while (may_idle && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_entry_handle <= hnd;
        i_entry_size   <= sz;
        i_char_offset  <= off;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // track the newest record sizes so finds can aim inside the ring
        if (cmd == wrol_pkg::CMD_ADD) begin
            add_count++;
            recent_sizes.push_back(sz);
            if (recent_sizes.size() > RING_DEPTH)
                void'(recent_sizes.pop_front());
        end else begin
            find_count++;
        end
    endtask

    // Drop valid and hold off until every outstanding reply has come back.
    // The checker's count is registered, so look only from the next edge on.
    task automatic drain_unit();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic                 cmd;
        logic [HANDLE_W-1:0]  hnd;
        logic [SIZE_BITS-1:0] sz;
        logic [OFFSET_W-1:0]  off;
        int unsigned          span;
        int unsigned          pick;
        bit                   may_idle;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= wrol_pkg::CMD_ADD;
        i_entry_handle <= '0;
        i_entry_size   <= '0;
        i_char_offset  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // -------- directed part --------
        // find on an empty ring misses
        offer(wrol_pkg::CMD_FIND, '1, SIZE_MAX, '0, 1'b1);
        // largest handle and size
        offer(wrol_pkg::CMD_ADD, '1, SIZE_MAX, OFFSET_MAX, 1'b1);
        // first byte, last byte, then just past the end of a partial ring
        offer(wrol_pkg::CMD_FIND, '0, '0, '0, 1'b1);
        offer(wrol_pkg::CMD_FIND, '0, '0, OFFSET_W'(SIZE_MAX) - OFFSET_W'(1), 1'b1);
        offer(wrol_pkg::CMD_FIND, '0, '0, OFFSET_W'(SIZE_MAX), 1'b1);
        // zero handle stored as given; a walk that reaches it stops
        offer(wrol_pkg::CMD_ADD, '0, SIZE_BITS'(5), '0, 1'b1);
        offer(wrol_pkg::CMD_FIND, '0, '0, OFFSET_W'(SIZE_MAX) + OFFSET_W'(1), 1'b1);
        // fill the ring; the last add reports it full
        for (int k = 0; k < RING_DEPTH - 2; k++)
            offer(wrol_pkg::CMD_ADD, HANDLE_W'(32'h1000_0002 + k),
                  SIZE_BITS'((k + 1) * 16), '0, 1'b1);
        // largest offset on a full ring
        offer(wrol_pkg::CMD_FIND, '0, '0, OFFSET_MAX, 1'b1);
        // overwrite the oldest record, then overwrite the zero-handle record
        // (still reported as an eviction) with a zero-size record
        offer(wrol_pkg::CMD_ADD, 32'hA5A5_0017, SIZE_BITS'(1), '0, 1'b1);
        offer(wrol_pkg::CMD_ADD, 32'h5A5A_0018, '0, '0, 1'b1);
        offer(wrol_pkg::CMD_FIND, '0, '0, '0, 1'b1);
        drain_unit();

        // -------- random part --------
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm_phase <= (n >= 500 && n < 700);
            may_idle = !(n >= 500 && n < 700);
            // long reply hold-off while commands keep coming
            if (n == 200)
                hold_request <= 1'b1;
            if (n == 900)
                drain_unit();

            cmd = ($urandom_range(0, 99) < 45) ? wrol_pkg::CMD_ADD : wrol_pkg::CMD_FIND;
            hnd = $urandom;
            sz  = SIZE_BITS'($urandom);
            off = OFFSET_W'($urandom);
            if (cmd == wrol_pkg::CMD_ADD) begin
                if ($urandom_range(0, 63) == 0)
                    hnd = '0;
                pick = $urandom_range(0, 63);
                if (pick == 0)
                    sz = '0;
                else if (pick < 9)
                    sz = SIZE_BITS'($urandom_range(1, int'(SIZE_MAX)));
                else
                    sz = SIZE_BITS'($urandom_range(1, 4096));
            end else begin
                span = 0;
                foreach (recent_sizes[k])
                    span += recent_sizes[k];
                pick = $urandom_range(0, 99);
                // mostly inside the stored bytes, some at the end boundary,
                // some anywhere in the offset range
                if (pick < 10)
                    off = OFFSET_W'($urandom_range(0, int'(OFFSET_MAX)));
                else if (pick < 20)
                    off = OFFSET_W'(span - $urandom_range(0, 1));
                else if (span != 0)
                    off = OFFSET_W'($urandom_range(0, span - 1));
                else
                    off = '0;
            end
            offer(cmd, hnd, sz, off, may_idle);
        end

        drain_unit();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d adds (%0d overwrote an older record) and %0d finds",
                 add_count, evict_count, find_count);
        $display("%0d finds located a record; the rest missed on empty, zero or past-end",
                 hit_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d replies missing", fail_count, pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/wrol_pkg.sv
rtl/wrol_ram.sv
rtl/wrol_step.sv
rtl/write_ring_offset_lookup_unit.sv
rtl/wrol_checker.sv
bench/ring_lookup_checker.sv
bench/tb.sv
